// File: sv/cartesian_spherical_converter_assert.svh
// assertion macros for the coordinate converter
`ifndef CARTESIAN_SPHERICAL_CONVERTER_ASSERT_SVH
`define CARTESIAN_SPHERICAL_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
`define CSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define CSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/csc_pkg.sv
package csc_pkg;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic signed [31:0] result_c;
    logic              overflow;
  } result_t;

  localparam int SQRT_STAGES = 32;
  localparam int VEC_W = 52;
  localparam int ROT_W = 34;

  localparam logic signed [31:0] PI_Q28      = 32'sd843314856;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629712;
  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
  localparam logic signed [31:0] SAT_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN     = 32'sh80000000;

  // atan(2^-i) in Q3.28
  localparam logic signed [31:0] ATAN_TAB [32] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2, 32'sd1, 32'sd0, 32'sd0, 32'sd0
  };

  function automatic logic over32(input logic signed [37:0] v);
    over32 = (v > 38'sd2147483647) || (v < -38'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      sat32 = SAT_MAX;
    end else if (v < -38'sd2147483648) begin
      sat32 = SAT_MIN;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

endpackage

// File: sv/csc_isqrt.sv
module csc_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import csc_pkg::*;

  logic [63:0] rem_q [SQRT_STAGES];
  logic [63:0] res_q [SQRT_STAGES];

  // one result bit per stage, floor root
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int Sh = 2 * (SQRT_STAGES - 1 - k);
    logic [63:0] v_in;
    logic [63:0] r_in;
    logic [64:0] trial;

    if (k == 0) begin : g_first
      assign v_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = rem_q[k-1];
      assign r_in = res_q[k-1];
    end

    assign trial = {1'b0, r_in} + (65'd1 << Sh);

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v_in} >= trial) begin
          rem_q[k] <= v_in - trial[63:0];
          res_q[k] <= (r_in >> 1) + (64'd1 << Sh);
        end else begin
          rem_q[k] <= v_in;
          res_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root = res_q[SQRT_STAGES-1][31:0];

endmodule

// File: sv/csc_vec.sv
module csc_vec #(
  parameter int ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a_in,
  input  logic signed [32:0] b_in,
  output logic signed [31:0] angle
);
  import csc_pkg::*;

  logic signed [VEC_W-1:0] sa, sb, pa_next, pb_next;
  logic signed [31:0]      pacc_next, pval_next;
  logic                    pspec_next;

  logic signed [VEC_W-1:0] pa, pb;
  logic signed [31:0]      pacc, pval;
  logic                    pspec;

  logic signed [VEC_W-1:0] ia   [ITERATIONS];
  logic signed [VEC_W-1:0] ib   [ITERATIONS];
  logic signed [31:0]      iacc [ITERATIONS];
  logic signed [31:0]      ival [ITERATIONS];
  logic                    ispec [ITERATIONS];

  assign sa = {{(VEC_W-49){a_in[32]}}, a_in, 16'b0};
  assign sb = {{(VEC_W-49){b_in[32]}}, b_in, 16'b0};

  always_comb begin
    pspec_next = 1'b0;
    pval_next  = '0;
    if (b_in == '0) begin
      pspec_next = 1'b1;
      pval_next  = (a_in < 0) ? PI_Q28 : '0;
    end else if (a_in == '0) begin
      pspec_next = 1'b1;
      pval_next  = (b_in > 0) ? HALF_PI_Q28 : -HALF_PI_Q28;
    end
    // left half plane: turn by a quarter first
    if (a_in < 0) begin
      if (b_in > 0) begin
        pa_next   = sb;
        pb_next   = -sa;
        pacc_next = HALF_PI_Q28;
      end else begin
        pa_next   = -sb;
        pb_next   = sa;
        pacc_next = -HALF_PI_Q28;
      end
    end else begin
      pa_next   = sa;
      pb_next   = sb;
      pacc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= pa_next;
      pb    <= pb_next;
      pacc  <= pacc_next;
      pspec <= pspec_next;
      pval  <= pval_next;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic signed [VEC_W-1:0] a_s, b_s;
    logic signed [31:0]      acc_s, val_s;
    logic                    spec_s;

    if (i == 0) begin : g_first
      assign a_s    = pa;
      assign b_s    = pb;
      assign acc_s  = pacc;
      assign val_s  = pval;
      assign spec_s = pspec;
    end else begin : g_next
      assign a_s    = ia[i-1];
      assign b_s    = ib[i-1];
      assign acc_s  = iacc[i-1];
      assign val_s  = ival[i-1];
      assign spec_s = ispec[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (b_s >= 0) begin
          ia[i]   <= a_s + (b_s >>> i);
          ib[i]   <= b_s - (a_s >>> i);
          iacc[i] <= acc_s + ATAN_TAB[i];
        end else begin
          ia[i]   <= a_s - (b_s >>> i);
          ib[i]   <= b_s + (a_s >>> i);
          iacc[i] <= acc_s - ATAN_TAB[i];
        end
        ival[i]  <= val_s;
        ispec[i] <= spec_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= ispec[ITERATIONS-1] ? ival[ITERATIONS-1] : iacc[ITERATIONS-1];
    end
  end

endmodule

// File: sv/csc_rot.sv
module csc_rot #(
  parameter int ITERATIONS = 24
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [31:0]               angle,
  output logic signed [csc_pkg::ROT_W-1:0] cos_q,
  output logic signed [csc_pkg::ROT_W-1:0] sin_q
);
  import csc_pkg::*;

  logic signed [32:0] ang_ext, r0_ang, r1_ang_next;
  logic               r1_neg_next;
  logic signed [32:0] r0_ang_next;

  logic signed [32:0] r1_ang;
  logic               r1_neg;

  logic signed [ROT_W-1:0] ia [ITERATIONS];
  logic signed [ROT_W-1:0] ib [ITERATIONS];
  logic signed [32:0]      iz [ITERATIONS];
  logic                    ineg [ITERATIONS];

  assign ang_ext = 33'(angle);

  // fold once by two pi into (-pi, pi]
  always_comb begin
    if (ang_ext > 33'(PI_Q28)) begin
      r0_ang_next = ang_ext - 33'(TWO_PI_Q28);
    end else if (ang_ext <= -33'(PI_Q28)) begin
      r0_ang_next = ang_ext + 33'(TWO_PI_Q28);
    end else begin
      r0_ang_next = ang_ext;
    end
  end

  // then into the right half plane, sign flip of both outputs
  always_comb begin
    r1_neg_next = 1'b0;
    r1_ang_next = r0_ang;
    if (r0_ang > 33'(HALF_PI_Q28)) begin
      r1_ang_next = r0_ang - 33'(PI_Q28);
      r1_neg_next = 1'b1;
    end else if (r0_ang < -33'(HALF_PI_Q28)) begin
      r1_ang_next = r0_ang + 33'(PI_Q28);
      r1_neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_ang <= r0_ang_next;
      r1_ang <= r1_ang_next;
      r1_neg <= r1_neg_next;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic signed [ROT_W-1:0] a_s, b_s;
    logic signed [32:0]      z_s;
    logic                    neg_s;

    if (i == 0) begin : g_first
      assign a_s   = ROT_W'(GAIN_Q30);
      assign b_s   = '0;
      assign z_s   = r1_ang;
      assign neg_s = r1_neg;
    end else begin : g_next
      assign a_s   = ia[i-1];
      assign b_s   = ib[i-1];
      assign z_s   = iz[i-1];
      assign neg_s = ineg[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_s >= 0) begin
          ia[i] <= a_s - (b_s >>> i);
          ib[i] <= b_s + (a_s >>> i);
          iz[i] <= z_s - 33'(ATAN_TAB[i]);
        end else begin
          ia[i] <= a_s + (b_s >>> i);
          ib[i] <= b_s - (a_s >>> i);
          iz[i] <= z_s + 33'(ATAN_TAB[i]);
        end
        ineg[i] <= neg_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= ineg[ITERATIONS-1] ? -ia[ITERATIONS-1] : ia[ITERATIONS-1];
      sin_q <= ineg[ITERATIONS-1] ? -ib[ITERATIONS-1] : ib[ITERATIONS-1];
    end
  end

endmodule

// File: sv/cartesian_spherical_converter.sv
// throughput: one item per cycle unless the result side stalls; set by the 32-stage root
// pipeline and the CORDIC pipelines, one stage per iteration
// a stall on the result side freezes the whole pipeline, nothing is lost or repeated
// reset (synchronous) clears the valid bits only
`include "cartesian_spherical_converter_assert.svh"

module cartesian_spherical_converter #(
  parameter int ITERATIONS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  csc_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output csc_pkg::result_t result
);
  import csc_pkg::*;

  localparam int CORDIC_LAT = ITERATIONS + 3;
  localparam int LAT = 3 + SQRT_STAGES + CORDIC_LAT + 4;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } sq_sb_t;

  typedef struct packed {
    logic              mode;
    logic              ovf;
    logic [31:0]       r;
    logic signed [31:0] a;
  } cr_sb_t;

  logic           en;
  logic [LAT-1:0] vld;

  // front: squares and sums
  sq_sb_t      s1, s2, s3;
  logic [63:0] s1_aa, s1_bb, s1_cc, s2_xy, s2_cc, s3_r2, s3_xy;

  sq_sb_t      sqa [SQRT_STAGES];
  logic [31:0] root_r, root_rho;
  cr_sb_t      cr_in;
  cr_sb_t      cra [CORDIC_LAT];

  logic signed [31:0]      vec_theta, vec_phi, post_theta, post_phi;
  logic signed [32:0]      phi_ext;
  logic signed [ROT_W-1:0] t_cos, t_sin, p_cos, p_sin;

  // back: mode 1 products, results carried alongside
  logic                    t1_mode, t2_mode, t3_mode;
  logic                    t1_ovf, t2_ovf, t3_ovf;
  logic [31:0]             t1_r, t2_r, t3_r;
  logic signed [31:0]      t1_th, t2_th, t3_th, t1_ph, t2_ph, t3_ph;
  logic signed [65:0]      t1_pst, t1_pct;
  logic signed [ROT_W-1:0] t1_cp, t1_sp, t2_cp, t2_sp;
  logic signed [33:0]      t2_rs, t2_zq, t3_zq;
  logic signed [67:0]      t3_px, t3_py;
  logic signed [37:0]      rnd_x, rnd_y, ext_z;
  logic                    ovf1;

  localparam logic signed [65:0] RND66 = 66'sd536870912;
  localparam logic signed [67:0] RND68 = 68'sd536870912;

  assign en         = !vld[LAT-1] || result_ready;
  assign item_ready = en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= '{mode: item.mode, a: item.coord_a, b: item.coord_b, c: item.coord_c};
      s1_aa <= 64'(item.coord_a * item.coord_a);
      s1_bb <= 64'(item.coord_b * item.coord_b);
      s1_cc <= 64'(item.coord_c * item.coord_c);
      s2    <= s1;
      s2_xy <= s1_aa + s1_bb;
      s2_cc <= s1_cc;
      s3    <= s2;
      s3_r2 <= s2_xy + s2_cc;
      s3_xy <= s2_xy;
    end
  end

  csc_isqrt u_sqrt_r (
    .clk      (clk),
    .en       (en),
    .radicand (s3_r2),
    .root     (root_r)
  );

  csc_isqrt u_sqrt_rho (
    .clk      (clk),
    .en       (en),
    .radicand (s3_xy),
    .root     (root_rho)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sqa[0] <= s3;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sqa[k] <= sqa[k-1];
      end
    end
  end

  // radius above the format saturates
  assign cr_in = '{mode: sqa[SQRT_STAGES-1].mode,
                   ovf:  root_r[31],
                   r:    root_r[31] ? SAT_MAX : root_r,
                   a:    sqa[SQRT_STAGES-1].a};

  always_ff @(posedge clk) begin
    if (en) begin
      cra[0] <= cr_in;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        cra[k] <= cra[k-1];
      end
    end
  end

  csc_vec #(.ITERATIONS(ITERATIONS)) u_vec_theta (
    .clk   (clk),
    .en    (en),
    .a_in  (33'(sqa[SQRT_STAGES-1].c)),
    .b_in  ({1'b0, root_rho}),
    .angle (vec_theta)
  );

  csc_vec #(.ITERATIONS(ITERATIONS)) u_vec_phi (
    .clk   (clk),
    .en    (en),
    .a_in  (33'(sqa[SQRT_STAGES-1].a)),
    .b_in  (33'(sqa[SQRT_STAGES-1].b)),
    .angle (vec_phi)
  );

  csc_rot #(.ITERATIONS(ITERATIONS)) u_rot_theta (
    .clk   (clk),
    .en    (en),
    .angle (sqa[SQRT_STAGES-1].b),
    .cos_q (t_cos),
    .sin_q (t_sin)
  );

  csc_rot #(.ITERATIONS(ITERATIONS)) u_rot_phi (
    .clk   (clk),
    .en    (en),
    .angle (sqa[SQRT_STAGES-1].c),
    .cos_q (p_cos),
    .sin_q (p_sin)
  );

  assign phi_ext = 33'(vec_phi);

  // theta clamped to [0, pi], phi folded into (-pi, pi]
  always_ff @(posedge clk) begin
    if (en) begin
      if (vec_theta < 0) begin
        post_theta <= '0;
      end else if (vec_theta > PI_Q28) begin
        post_theta <= PI_Q28;
      end else begin
        post_theta <= vec_theta;
      end
      if (phi_ext > 33'(PI_Q28)) begin
        post_phi <= 32'(phi_ext - 33'(TWO_PI_Q28));
      end else if (phi_ext <= -33'(PI_Q28)) begin
        post_phi <= 32'(phi_ext + 33'(TWO_PI_Q28));
      end else begin
        post_phi <= vec_phi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_mode <= cra[CORDIC_LAT-1].mode;
      t1_ovf  <= cra[CORDIC_LAT-1].ovf;
      t1_r    <= cra[CORDIC_LAT-1].r;
      t1_th   <= post_theta;
      t1_ph   <= post_phi;
      t1_pst  <= 66'(cra[CORDIC_LAT-1].a) * 66'(t_sin);
      t1_pct  <= 66'(cra[CORDIC_LAT-1].a) * 66'(t_cos);
      t1_cp   <= p_cos;
      t1_sp   <= p_sin;

      t2_mode <= t1_mode;
      t2_ovf  <= t1_ovf;
      t2_r    <= t1_r;
      t2_th   <= t1_th;
      t2_ph   <= t1_ph;
      t2_rs   <= 34'((t1_pst + RND66) >>> 30);
      t2_zq   <= 34'((t1_pct + RND66) >>> 30);
      t2_cp   <= t1_cp;
      t2_sp   <= t1_sp;

      t3_mode <= t2_mode;
      t3_ovf  <= t2_ovf;
      t3_r    <= t2_r;
      t3_th   <= t2_th;
      t3_ph   <= t2_ph;
      t3_px   <= 68'(t2_rs) * 68'(t2_cp);
      t3_py   <= 68'(t2_rs) * 68'(t2_sp);
      t3_zq   <= t2_zq;
    end
  end

  assign rnd_x = 38'((t3_px + RND68) >>> 30);
  assign rnd_y = 38'((t3_py + RND68) >>> 30);
  assign ext_z = 38'(t3_zq);
  assign ovf1  = over32(rnd_x) || over32(rnd_y) || over32(ext_z);

  always_ff @(posedge clk) begin
    if (en) begin
      if (t3_mode) begin
        result.result_a <= sat32(rnd_x);
        result.result_b <= sat32(rnd_y);
        result.result_c <= sat32(ext_z);
        result.overflow <= ovf1;
      end else begin
        result.result_a <= t3_r;
        result.result_b <= t3_th;
        result.result_c <= t3_ph;
        result.overflow <= t3_ovf;
      end
    end
  end

  `CSC_ASSERT_NEXT(a_stall_freeze, clk, rst, !en, $stable(vld), "valid bits moved during a stall")
  `CSC_ASSERT_NOW(a_rise_advance, clk, rst, $rose(result_valid), $past(en), "result appeared without advance")
  `CSC_ASSERT_NOW(a_ovf_saturated, clk, rst, result_valid && result.overflow, result.result_a == SAT_MAX || result.result_a == SAT_MIN || result.result_b == SAT_MAX || result.result_b == SAT_MIN || result.result_c == SAT_MAX || result.result_c == SAT_MIN, "overflow without a saturated field")

endmodule

// File: verif/tb_cartesian_spherical_converter.sv
module tb_cartesian_spherical_converter;
  import csc_pkg::*;

  localparam int CORDIC_STAGES = 24;
  localparam int PIPE_DEPTH    = CORDIC_STAGES + 42;
  localparam int RANDOM_ITEMS  = 830;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam logic MODE_TO_SPH  = 1'b0;
  localparam logic MODE_TO_CART = 1'b1;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t expected_q[$];
  item_t   row_item[$];
  logic    row_known[$];
  result_t row_result[$];

  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_cart = 0;
  int   n_ovf = 0;
  int   phase = 0;
  int   quiet = 0;
  logic stim_done = 1'b0;

  cartesian_spherical_converter #(.ITERATIONS(CORDIC_STAGES)) DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, angle of (p, q) in q3.28, unfolded
  function automatic longint vector_angle(longint p, longint q);
    longint acc;
    longint t;
    longint np;
    longint nq;
    acc = 0;
    if (q == 0) return (p < 0) ? longint'(PI_Q28) : 0;
    if (p == 0) return (q > 0) ? longint'(HALF_PI_Q28) : -longint'(HALF_PI_Q28);
    p = p * 65536;
    q = q * 65536;
    if (p < 0) begin
      t = p;
      if (q > 0) begin
        p = q; q = -t; acc = HALF_PI_Q28;
      end else begin
        p = -q; q = t; acc = -longint'(HALF_PI_Q28);
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (q >= 0) begin
        np = p + (q >>> i); nq = q - (p >>> i); acc = acc + ATAN_TAB[i];
      end else begin
        np = p - (q >>> i); nq = q + (p >>> i); acc = acc - ATAN_TAB[i];
      end
      p = np; q = nq;
    end
    return acc;
  endfunction

  // rotation cordic, cosine and sine in q1.30
  function automatic void rotate_unit(longint ang, output longint cs, output longint sn);
    longint p;
    longint q;
    longint np;
    longint nq;
    logic   flip;
    p = GAIN_Q30;
    q = 0;
    flip = 1'b0;
    if (ang > PI_Q28) ang = ang - TWO_PI_Q28;
    else if (ang <= -longint'(PI_Q28)) ang = ang + TWO_PI_Q28;
    if (ang > HALF_PI_Q28) begin
      ang = ang - PI_Q28; flip = 1'b1;
    end else if (ang < -longint'(HALF_PI_Q28)) begin
      ang = ang + PI_Q28; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (ang >= 0) begin
        np = p - (q >>> i); nq = q + (p >>> i); ang = ang - ATAN_TAB[i];
      end else begin
        np = p + (q >>> i); nq = q - (p >>> i); ang = ang + ATAN_TAB[i];
      end
      p = np; q = nq;
    end
    cs = flip ? -p : p;
    sn = flip ? -q : q;
  endfunction

  function automatic longint scale_q30(longint len, longint f);
    return (len * f + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp32(longint v, ref logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1; return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic result_t convert(item_t x);
    result_t r;
    longint a;
    longint b;
    longint c;
    longint va;
    longint vb;
    longint vc;
    longint rs;
    longint ct;
    longint st;
    longint cp;
    longint sp;
    longint unsigned xy2;
    logic ovf;
    a = x.coord_a;
    b = x.coord_b;
    c = x.coord_c;
    ovf = 1'b0;
    if (x.mode == MODE_TO_SPH) begin
      xy2 = longint'(a * a) + longint'(b * b);
      va = clamp32(longint'(int_root(xy2 + longint'(c * c))), ovf);
      vb = vector_angle(c, longint'(int_root(xy2)));
      if (vb < 0) vb = 0;
      if (vb > PI_Q28) vb = PI_Q28;
      vc = vector_angle(a, b);
      if (vc > PI_Q28) vc = vc - TWO_PI_Q28;
      else if (vc <= -longint'(PI_Q28)) vc = vc + TWO_PI_Q28;
    end else begin
      rotate_unit(b, ct, st);
      rotate_unit(c, cp, sp);
      rs = scale_q30(a, st);
      va = clamp32(scale_q30(rs, cp), ovf);
      vb = clamp32(scale_q30(rs, sp), ovf);
      vc = clamp32(scale_q30(a, ct), ovf);
    end
    r.result_a = 32'(va);
    r.result_b = 32'(vb);
    r.result_c = 32'(vc);
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  task automatic add_row(logic m, logic signed [31:0] a, logic signed [31:0] b,
                         logic signed [31:0] c, logic known, result_t r);
    item_t x;
    x.mode = m; x.coord_a = a; x.coord_b = b; x.coord_c = c;
    row_item.push_back(x);
    row_known.push_back(known);
    row_result.push_back(r);
  endtask

  function automatic result_t res(logic signed [31:0] a, logic signed [31:0] b,
                                  logic signed [31:0] c, logic o);
    result_t r;
    r.result_a = a; r.result_b = b; r.result_c = c; r.overflow = o;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_len();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(32'h1FFFFF)) - 32'sh100000;
      3:    return $signed($urandom_range(32'h1FFFFFF)) - 32'sh1000000;
      4:    return 32'sd0;
      default: return $signed($urandom_range(32'hFFFF)) - 32'sh8000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_angle();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(32'h7FFFFFFF)) - 32'sh40000000;
      2: return ($urandom_range(1) != 0) ? PI_Q28 : -PI_Q28;
      default: return $signed($urandom_range(32'h3FFFFFFF)) - 32'sh20000000;
    endcase
  endfunction

  task automatic offer(item_t x, logic known, result_t r, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= x;
    do @(negedge clk); while (!item_ready);
    expected_q.push_back(known ? r : convert(x));
    n_sent++;
    if (x.mode == MODE_TO_CART) n_cart++;
    @(posedge clk);
  endtask

  initial begin
    item_t x;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_row(MODE_TO_SPH, 0, 0, 0, 1, res(0, 0, 0, 0));
    add_row(MODE_TO_SPH, 0, 0, 5 * ONE_Q16, 1, res(5 * ONE_Q16, 0, 0, 0));
    add_row(MODE_TO_SPH, 0, 0, -5 * ONE_Q16, 1, res(5 * ONE_Q16, PI_Q28, 0, 0));
    add_row(MODE_TO_SPH, 0, 3 * ONE_Q16, 0, 1,
            res(3 * ONE_Q16, HALF_PI_Q28, HALF_PI_Q28, 0));
    add_row(MODE_TO_SPH, 0, -3 * ONE_Q16, 0, 1,
            res(3 * ONE_Q16, HALF_PI_Q28, -HALF_PI_Q28, 0));
    add_row(MODE_TO_SPH, -2 * ONE_Q16, 0, 0, 1,
            res(2 * ONE_Q16, HALF_PI_Q28, PI_Q28, 0));
    add_row(MODE_TO_SPH, 2 * ONE_Q16, 0, 0, 1, res(2 * ONE_Q16, HALF_PI_Q28, 0, 0));
    // radius of exactly 2^31 lsb saturates
    add_row(MODE_TO_SPH, SAT_MIN, 0, 0, 1, res(SAT_MAX, HALF_PI_Q28, PI_Q28, 1));
    add_row(MODE_TO_SPH, SAT_MAX, SAT_MAX, SAT_MAX, 0, '0);
    add_row(MODE_TO_SPH, SAT_MIN, SAT_MIN, SAT_MIN, 0, '0);
    add_row(MODE_TO_SPH, -ONE_Q16, -ONE_Q16, ONE_Q16, 0, '0);
    add_row(MODE_TO_SPH, 7 * ONE_Q16, -3 * ONE_Q16, -ONE_Q16, 0, '0);
    add_row(MODE_TO_SPH, -1, 1, -1, 0, '0);
    add_row(MODE_TO_CART, 0, SAT_MAX, SAT_MIN, 1, res(0, 0, 0, 0));
    add_row(MODE_TO_CART, ONE_Q16, 0, 0, 0, '0);
    add_row(MODE_TO_CART, SAT_MAX, HALF_PI_Q28, 0, 0, '0);
    add_row(MODE_TO_CART, SAT_MIN, PI_Q28, -PI_Q28, 0, '0);
    add_row(MODE_TO_CART, SAT_MAX, -PI_Q28, PI_Q28, 0, '0);
    add_row(MODE_TO_CART, -4 * ONE_Q16, HALF_PI_Q28 / 2, HALF_PI_Q28 / 2, 0, '0);
    add_row(MODE_TO_CART, ONE_Q16, SAT_MAX, SAT_MIN, 0, '0);
    add_row(MODE_TO_CART, SAT_MAX, HALF_PI_Q28 / 2, HALF_PI_Q28 / 2, 0, '0);
    add_row(MODE_TO_CART, ONE_Q16, -HALF_PI_Q28, TWO_PI_Q28, 0, '0);

    foreach (row_item[i]) offer(row_item[i], row_known[i], row_result[i], 31);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n * 3) / RANDOM_ITEMS;
      x.mode = $urandom_range(1);
      x.coord_a = pick_len();
      if (x.mode == MODE_TO_SPH) begin
        x.coord_b = pick_len();
        x.coord_c = pick_len();
      end else begin
        x.coord_b = pick_angle();
        x.coord_c = pick_angle();
      end
      offer(x, 1'b0, '0, (phase == 0) ? 31 : (phase == 1) ? 80 : 0);
    end
    item_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random back-pressure plus one long hold to fill the pipe
  initial begin
    int hold;
    logic held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= $urandom_range(99) >= ((phase == 0) ? 80 : (phase == 1) ? 31 : 0);
      end
    end
  end

  always @(negedge clk) begin
    result_t want;
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_cartesian_spherical_converter failed");
      $finish;
    end
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("mismatch: result transfer with nothing outstanding");
      end else begin
        want = expected_q.pop_front();
        if (result.result_a !== want.result_a) report("result_a", result.result_a, want.result_a);
        if (result.result_b !== want.result_b) report("result_b", result.result_b, want.result_b);
        if (result.result_c !== want.result_c) report("result_c", result.result_c, want.result_c);
        if (result.overflow !== want.overflow)
          report("overflow", 32'(result.overflow), 32'(want.overflow));
        if (want.overflow) n_ovf++;
        n_checked++;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (expected_q.size() != 0) errors++;
    $display("covered %0d vectors (%0d to cartesian), %0d checked, %0d saturated",
             n_sent, n_cart, n_checked, n_ovf);
    $display("idle mixes on both sides and a %0d cycle output hold, %0d errors",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("tb_cartesian_spherical_converter passed");
    end else begin
      $display("tb_cartesian_spherical_converter failed");
    end
    $finish;
  end

endmodule
